### rtl/core/stt_pkg.sv
// Shared types and constants for the sparse triplet transpose block
package stt_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int MAX_DIM     = 64;

    localparam int IDX_W  = 6;
    localparam int VAL_W  = 32;
    localparam int CFG_W  = 7;
    localparam int ADDR_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

    localparam logic [CFG_W-1:0] COL_COUNT_RESET = CFG_W'(4);
    localparam logic [CFG_W-1:0] SWEEP_MAX       = CFG_W'(MAX_DIM);
    localparam logic [CNT_W-1:0] CNT_FULL        = CNT_W'(MAX_ENTRIES);

    // One input request
    typedef struct packed {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
        logic                    has_entry;
        logic                    is_last;
    } stt_in_t;

    // One result
    typedef struct packed {
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic signed [VAL_W-1:0] out_value;
        logic                    out_last;
        logic                    empty_res;
        logic                    overflow;
    } stt_out_t;

    // One stored entry
    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [VAL_W-1:0] value;
    } stt_entry_t;

    localparam int ENTRY_W = $bits(stt_entry_t);

    // Commands from controller to datapath
    typedef struct packed {
        logic load_en;
        logic sweep_init;
        logic col_adv;
        logic rd_en;
        logic idx_adv;
        logic take_match;
        logic finish;
    } stt_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic last_accept;
        logic col_done;
        logic idx_done;
        logic match;
        logic out_free;
        logic pend_valid;
    } stt_sts_t;

endpackage

### rtl/core/stt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
module stt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/stt_ctrl.sv
// Controller state machine for load, column sweep and final result
module stt_ctrl
    import stt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  stt_sts_t sts,
    output stt_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_LOAD   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_CMP    = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Decode commands and next state
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                cmd.load_en = 1'b1;
                if (sts.last_accept)
                begin
                    cmd.sweep_init = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.col_done)
                begin
                    state_next = ST_FINISH;
                end
                else if (sts.idx_done)
                begin
                    cmd.col_adv = 1'b1;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (!sts.match)
                begin
                    cmd.idx_adv = 1'b1;
                    state_next  = ST_SCAN;
                end
                else if (!sts.pend_valid || sts.out_free)
                begin
                    cmd.take_match = 1'b1;
                    cmd.idx_adv    = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

### rtl/core/stt_dp.sv
// Datapath: entry store, sweep counters, pending result and output register
module stt_dp
    import stt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  stt_cmd_t         cmd,
    output stt_sts_t         sts,
    input  logic             item_valid,
    output logic             item_stall,
    input  stt_in_t          item_data,
    output logic             result_valid,
    input  logic             result_stall,
    output stt_out_t         result_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    logic [CFG_W-1:0] col_count_reg;
    logic [CNT_W-1:0] count_reg;
    logic             dropped_reg;
    logic [CFG_W-1:0] col_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             pend_valid_reg;
    stt_entry_t       pend_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    stt_out_t         out_reg;

    logic             accept;
    logic             wr_en;
    logic             room;
    stt_entry_t       wr_entry;
    stt_entry_t       rd_entry;
    logic [ENTRY_W-1:0] rd_bits;
    logic [CFG_W-1:0] sweep;
    logic             out_free;
    logic             push_pend;

    // Handshakes
    assign item_stall = !cmd.load_en;
    assign cfg_ready  = cmd.load_en;
    assign accept     = item_valid && cmd.load_en;
    assign room       = (count_reg < CNT_FULL);
    assign wr_en      = accept && item_data.has_entry && room;

    assign wr_entry.row   = item_data.row;
    assign wr_entry.col   = item_data.col;
    assign wr_entry.value = item_data.value;

    // Entry store
    stt_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_ENTRIES)
    ) u_store (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(count_reg[ADDR_W-1:0]),
        .wr_data(wr_entry),
        .rd_en  (cmd.rd_en),
        .rd_addr(idx_reg[ADDR_W-1:0]),
        .rd_data(rd_bits)
    );

    assign rd_entry = stt_entry_t'(rd_bits);

    // Clamp the sweep to the largest column range
    assign sweep = (col_count_reg > SWEEP_MAX) ? SWEEP_MAX : col_count_reg;

    assign out_free  = !out_valid_reg || !result_stall;
    assign push_pend = cmd.take_match && pend_valid_reg;

    // Status back to the controller
    assign sts.last_accept = accept && item_data.is_last;
    assign sts.col_done    = (col_reg >= sweep);
    assign sts.idx_done    = (idx_reg == count_reg);
    assign sts.match       = (rd_entry.col == col_reg[IDX_W-1:0]);
    assign sts.out_free    = out_free;
    assign sts.pend_valid  = pend_valid_reg;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= COL_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            col_count_reg <= cfg_data;
        end
    end

    // Fill count and drop flag; clear after the final result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else if (accept && item_data.has_entry)
        begin
            if (room)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else
            begin
                dropped_reg <= 1'b1;
            end
        end
    end

    // Sweep counters: column outer, entry index inner
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            idx_reg <= '0;
        end
        else if (cmd.sweep_init)
        begin
            col_reg <= '0;
            idx_reg <= '0;
        end
        else if (cmd.col_adv)
        begin
            col_reg <= col_reg + CFG_W'(1);
            idx_reg <= '0;
        end
        else if (cmd.idx_adv)
        begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
    end

    // Hold the latest match until the next one shows it is not the last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (cmd.take_match)
        begin
            pend_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_match)
        begin
            pend_reg <= rd_entry;
        end
    end

    // Output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg && result_stall;
        if (push_pend || cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Output register payload: swap row and column, or mark an empty final result
    always_ff @(posedge clk)
    begin
        if (push_pend || (cmd.finish && pend_valid_reg))
        begin
            out_reg.out_row   <= pend_reg.col;
            out_reg.out_col   <= pend_reg.row;
            out_reg.out_value <= pend_reg.value;
            out_reg.out_last  <= cmd.finish;
            out_reg.empty_res <= 1'b0;
            out_reg.overflow  <= dropped_reg;
        end
        else if (cmd.finish)
        begin
            out_reg.out_row   <= '0;
            out_reg.out_col   <= '0;
            out_reg.out_value <= '0;
            out_reg.out_last  <= 1'b1;
            out_reg.empty_res <= 1'b1;
            out_reg.overflow  <= dropped_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_reg;

endmodule

### rtl/core/sparse_triplet_transpose.sv
// Sequence: the last request starts a sweep of min(col_count, 64) columns; for each column
// every stored entry is read and compared with it, and after the sweep the final result
// is loaded. Matches and the final result wait while the output stalls.
// Throughput: one request per cycle while loading; requests wait during the sweep and
// while the final result is loaded.
// Reset: col_count returns to 4, the store count and drop flag clear, no result is pending.
module sparse_triplet_transpose
    import stt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  stt_in_t          item_data,
    output logic             result_valid,
    input  logic             result_stall,
    output stt_out_t         result_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    stt_cmd_t cmd;
    stt_sts_t sts;

    // Sequence load, sweep and final result
    stt_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .sts  (sts),
        .cmd  (cmd)
    );

    // Store entries and build results
    stt_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .item_data   (item_data),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_data (result_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

endmodule
